FILE: rtl/pbfx_pkg.sv
// types and constants shared by the protobuf field extractor
package pbfx_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } pbfx_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [7:0]  payload_length;
        logic [7:0]  value_offset;
        logic        last_result;
    } pbfx_result_t;

    localparam logic [2:0] ST_VARINT     = 3'd0;
    localparam logic [2:0] ST_PAYLOAD    = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_BAD_WIRE   = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;

    localparam logic [2:0] PH_TAG      = 3'd0;
    localparam logic [2:0] PH_TAG2     = 3'd1;
    localparam logic [2:0] PH_VAR_SKIP = 3'd2;
    localparam logic [2:0] PH_VAR_HIT  = 3'd3;
    localparam logic [2:0] PH_LEN_SKIP = 3'd4;
    localparam logic [2:0] PH_LEN_HIT  = 3'd5;
    localparam logic [2:0] PH_PAYLOAD  = 3'd6;
    localparam logic [2:0] PH_SKIP     = 3'd7;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_LENGTH = 3'd2;

    localparam logic [7:0] TARGET_RESET   = 8'd15;
    localparam logic [7:0] VARINT_LENGTH  = 8'd4;
    localparam logic [2:0] VARINT_GROUPS  = 3'd5;

    typedef struct packed {
        logic step;
        logic space;
    } pbfx_flow_t;

endpackage

FILE: rtl/pbfx_input_reg.sv
// input register holding one byte transaction for the parser
module pbfx_input_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pbfx_pkg::pbfx_item_t in_item,
    input  pbfx_pkg::pbfx_flow_t flow,
    output logic                item_valid,
    output pbfx_pkg::pbfx_item_t item
);
    import pbfx_pkg::*;

    logic       valid_reg;
    pbfx_item_t item_reg;

    assign in_stall   = valid_reg && !flow.step;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: rtl/pbfx_parser.sv
// wire-format parser state and combinational next-state and result logic
module pbfx_parser #(
    parameter int MAX_BUFFER_BYTES = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pbfx_pkg::pbfx_flow_t  flow,
    input  pbfx_pkg::pbfx_item_t  item,
    input  logic [7:0]            target_field,
    output logic                  res_valid,
    output pbfx_pkg::pbfx_result_t res
);
    import pbfx_pkg::*;

    localparam logic [7:0] MAX_POS = 8'(MAX_BUFFER_BYTES);

    logic [2:0]  phase_reg,     phase_next;
    logic [7:0]  field_reg,     field_next;
    logic [2:0]  wire_reg,      wire_next;
    logic [31:0] accum_reg,     accum_next;
    logic [2:0]  groups_reg,    groups_next;
    logic [7:0]  remain_reg,    remain_next;
    logic [7:0]  pos_reg,       pos_next;
    logic [7:0]  match_reg,     match_next;
    logic        done_reg,      done_next;

    logic [7:0]  b;
    logic        eob;
    logic [7:0]  next_pos;
    logic [2:0]  disp_kind;
    logic [7:0]  disp_field;
    logic        disp_en;
    logic [31:0] group_bits;
    logic        pay_last;

    assign b   = item.data_byte;
    assign eob = item.end_of_buffer;

    always_comb
    begin
        next_pos = (pos_reg < MAX_POS) ? pos_reg + 8'd1 : MAX_POS;

        phase_next  = phase_reg;
        field_next  = field_reg;
        wire_next   = wire_reg;
        accum_next  = accum_reg;
        groups_next = groups_reg;
        remain_next = remain_reg;
        pos_next    = next_pos;
        match_next  = match_reg;
        done_next   = done_reg;

        res_valid = 1'b0;
        res       = '0;

        disp_en    = 1'b0;
        disp_kind  = b[2:0];
        disp_field = {4'd0, b[6:3]};
        pay_last   = (remain_reg <= 8'd1);

        unique case (groups_reg)
            3'd0:    group_bits = {25'd0, b[6:0]};
            3'd1:    group_bits = {18'd0, b[6:0], 7'd0};
            3'd2:    group_bits = {11'd0, b[6:0], 14'd0};
            3'd3:    group_bits = {4'd0, b[6:0], 21'd0};
            3'd4:    group_bits = {b[3:0], 28'd0};
            default: group_bits = '0;
        endcase

        if (!done_reg)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    if (b[7])
                    begin
                        field_next = {4'd0, b[6:3]};
                        wire_next  = b[2:0];
                        phase_next = PH_TAG2;
                    end
                    else
                    begin
                        disp_en = 1'b1;
                    end
                end
                PH_TAG2:
                begin
                    disp_en    = 1'b1;
                    disp_kind  = wire_reg;
                    disp_field = field_reg | {b[3:0], 4'd0};
                end
                PH_VAR_SKIP:
                begin
                    if (!b[7])
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_VAR_HIT:
                begin
                    if (groups_reg < VARINT_GROUPS)
                    begin
                        accum_next  = accum_reg + group_bits;
                        groups_next = groups_reg + 3'd1;
                    end
                    if (!b[7])
                    begin
                        done_next = 1'b1;
                        res_valid = 1'b1;
                        res = '{ST_VARINT, accum_next, VARINT_LENGTH, match_reg, 1'b1};
                    end
                end
                PH_LEN_SKIP:
                begin
                    if (b != 8'd0)
                    begin
                        remain_next = b;
                        phase_next  = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_LEN_HIT:
                begin
                    if (b == 8'd0)
                    begin
                        done_next = 1'b1;
                        res_valid = 1'b1;
                        res = '{ST_EMPTY, 32'd0, 8'd0, match_reg, 1'b1};
                    end
                    else
                    begin
                        remain_next = b;
                        accum_next  = {24'd0, b};
                        phase_next  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    res = '{ST_PAYLOAD, {24'd0, b}, accum_reg[7:0], match_reg, pay_last};
                    if (remain_reg != 8'd0)
                    begin
                        remain_next = remain_reg - 8'd1;
                    end
                    if (pay_last)
                    begin
                        done_next = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    if (remain_reg != 8'd0)
                    begin
                        remain_next = remain_reg - 8'd1;
                    end
                    if (remain_next == 8'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
            endcase

            if (disp_en)
            begin
                field_next = disp_field;
                if (disp_kind != WIRE_VARINT && disp_kind != WIRE_LENGTH)
                begin
                    done_next = 1'b1;
                    res_valid = 1'b1;
                    res = '{ST_BAD_WIRE, 32'd0, 8'd0, 8'd0, 1'b1};
                end
                else
                begin
                    match_next  = next_pos;
                    accum_next  = '0;
                    groups_next = '0;
                    if (disp_kind == WIRE_VARINT)
                    begin
                        phase_next = (disp_field == target_field) ? PH_VAR_HIT : PH_VAR_SKIP;
                    end
                    else
                    begin
                        phase_next = (disp_field == target_field) ? PH_LEN_HIT : PH_LEN_SKIP;
                    end
                end
            end
        end

        if (eob)
        begin
            if (!done_reg)
            begin
                if (res_valid)
                begin
                    if (!res.last_result)
                    begin
                        res = '{ST_TRUNCATED, {24'd0, b}, accum_next[7:0], match_next, 1'b1};
                    end
                end
                else
                begin
                    res_valid = 1'b1;
                    priority if (phase_next == PH_VAR_HIT)
                    begin
                        res = '{ST_TRUNCATED, 32'd0, VARINT_LENGTH, match_next, 1'b1};
                    end
                    else if (phase_next == PH_LEN_HIT)
                    begin
                        res = '{ST_TRUNCATED, 32'd0, 8'd0, match_next, 1'b1};
                    end
                    else if (phase_next == PH_PAYLOAD)
                    begin
                        res = '{ST_TRUNCATED, 32'd0, accum_next[7:0], match_next, 1'b1};
                    end
                    else
                    begin
                        res = '{ST_NOT_FOUND, 32'd0, 8'd0, 8'd0, 1'b1};
                    end
                end
            end
            phase_next  = PH_TAG;
            field_next  = '0;
            wire_next   = '0;
            accum_next  = '0;
            groups_next = '0;
            remain_next = '0;
            pos_next    = '0;
            match_next  = '0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            field_reg  <= '0;
            wire_reg   <= '0;
            accum_reg  <= '0;
            groups_reg <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            match_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else if (flow.step)
        begin
            phase_reg  <= phase_next;
            field_reg  <= field_next;
            wire_reg   <= wire_next;
            accum_reg  <= accum_next;
            groups_reg <= groups_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            done_reg   <= done_next;
        end
    end

endmodule

FILE: rtl/pbfx_output_reg.sv
// result register presenting one result transaction downstream
module pbfx_output_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   res_valid,
    input  pbfx_pkg::pbfx_result_t res,
    output pbfx_pkg::pbfx_flow_t   flow,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pbfx_pkg::pbfx_result_t out_item
);
    import pbfx_pkg::*;

    logic         valid_reg;
    pbfx_result_t res_reg;

    assign flow.space = !valid_reg || !out_stall;
    assign flow.step  = item_valid && flow.space;
    assign out_valid  = valid_reg;
    assign out_item   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (flow.step)
        begin
            valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.step && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: rtl/protobuf_field_extractor.sv
// top level of the protobuf field extractor
// Takes one buffer byte per cycle and sustains one byte per cycle for as long as
// the result side is not stalled; an accepted byte is held in the input register,
// the parser works on it combinationally, and its result is captured in the result
// register and presented from there. At most one result comes from each byte.
// target_field may be written only while no byte is in flight.
module protobuf_field_extractor #(
    parameter int MAX_BUFFER_BYTES = 255
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pbfx_pkg::pbfx_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pbfx_pkg::pbfx_result_t out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_data
);
    import pbfx_pkg::*;

    logic         cfg_write;
    logic [7:0]   target_field_reg;
    pbfx_flow_t   flow;
    logic         item_valid;
    pbfx_item_t   item;
    logic         res_valid;
    pbfx_result_t res;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_field_reg <= TARGET_RESET;
        end
        else if (cfg_write)
        begin
            target_field_reg <= cfg_data;
        end
    end

    pbfx_input_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .flow       (flow),
        .item_valid (item_valid),
        .item       (item)
    );

    pbfx_parser #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .flow         (flow),
        .item         (item),
        .target_field (target_field_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    pbfx_output_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res        (res),
        .flow       (flow),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

FILE: rtl/pbfx_checker.sv
// port-level assertions for the protobuf field extractor and their bind
module pbfx_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input pbfx_pkg::pbfx_result_t out_item
);
    import pbfx_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= ST_TRUNCATED)
        else $error("undefined status code");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_NOT_FOUND || out_item.status == ST_BAD_WIRE)
        |-> out_item.last_result && out_item.value == 32'd0
            && out_item.payload_length == 8'd0 && out_item.value_offset == 8'd0)
        else $error("bad fields on not found or bad wire type");

    a_varint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_VARINT
        |-> out_item.last_result && out_item.payload_length == VARINT_LENGTH)
        else $error("varint result fields wrong");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_EMPTY
        |-> out_item.last_result && out_item.value == 32'd0
            && out_item.payload_length == 8'd0)
        else $error("empty payload fields wrong");

endmodule

bind protobuf_field_extractor pbfx_checker u_pbfx_checker (.*);
